// ===== src/ccc_pkg.sv =====
// Shared types, codes and month table for the calendar clock counter.
// No dependencies; imported by ccc_update and calendar_clock_counter.
package ccc_pkg;

  // Item codes
  typedef enum logic [1:0] {
    ACT_TICK = 2'd0,
    ACT_SET  = 2'd1,
    ACT_INIT = 2'd2
  } action_t;

  // Bit positions inside write_mask
  localparam int unsigned MSK_YEAR    = 0;
  localparam int unsigned MSK_MONTH   = 1;
  localparam int unsigned MSK_DAY     = 2;
  localparam int unsigned MSK_HOUR    = 3;
  localparam int unsigned MSK_MINUTE  = 4;
  localparam int unsigned MSK_SECOND  = 5;
  localparam int unsigned MSK_WEEKDAY = 6;

  localparam logic [15:0] YEAR_MAX    = 16'hFFFF;
  localparam logic [3:0]  MONTH_LAST  = 4'd12;
  localparam logic [4:0]  HOUR_LAST   = 5'd23;
  localparam logic [5:0]  MINUTE_LAST = 6'd59;
  localparam logic [5:0]  SECOND_LAST = 6'd59;
  localparam logic [2:0]  WDAY_LAST   = 3'd6;
  localparam logic [3:0]  MONTH_FEB   = 4'd2;

  // Input word
  typedef struct packed {
    logic [1:0]  action;
    logic [6:0]  write_mask;
    logic [15:0] new_year;
    logic [7:0]  new_month;
    logic [7:0]  new_day;
    logic [7:0]  new_hour;
    logic [7:0]  new_minute;
    logic [7:0]  new_second;
    logic [7:0]  new_weekday;
  } in_word_t;

  // Result word
  typedef struct packed {
    logic [15:0] cur_year;
    logic [3:0]  cur_month;
    logic [4:0]  cur_day;
    logic [4:0]  cur_hour;
    logic [5:0]  cur_minute;
    logic [5:0]  cur_second;
    logic [2:0]  cur_weekday;
    logic        minute_event;
  } out_word_t;

  // Calendar state
  typedef struct packed {
    logic [15:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [2:0]  weekday;
  } cal_t;

  // Power-on / init value: year 0, January 1, 00:00:00, Monday
  localparam cal_t CAL_INIT = '{
    year:    16'd0,
    month:   4'd1,
    day:     5'd1,
    hour:    5'd0,
    minute:  6'd0,
    second:  6'd0,
    weekday: 3'd1
  };

  // Days in a month, non-leap; 0 for codes that are not a month
  function automatic logic [4:0] month_len(input logic [3:0] month);
    logic [4:0] len;
    case (month)
      4'd1:    len = 5'd31;
      4'd2:    len = 5'd28;
      4'd3:    len = 5'd31;
      4'd4:    len = 5'd30;
      4'd5:    len = 5'd31;
      4'd6:    len = 5'd30;
      4'd7:    len = 5'd31;
      4'd8:    len = 5'd31;
      4'd9:    len = 5'd30;
      4'd10:   len = 5'd31;
      4'd11:   len = 5'd30;
      4'd12:   len = 5'd31;
      default: len = 5'd0;
    endcase
    return len;
  endfunction

  // 8-bit value mod 7: 8 = 1 (mod 7), so octal digits fold into a small sum
  function automatic logic [2:0] mod7(input logic [7:0] v);
    logic [4:0] s1;
    logic [3:0] s2;
    s1 = {3'd0, v[7:6]} + {2'd0, v[5:3]} + {2'd0, v[2:0]};
    s2 = {2'd0, s1[4:3]} + {1'b0, s1[2:0]};
    if (s2 >= 4'd7) begin
      s2 = s2 - 4'd7;
    end
    return s2[2:0];
  endfunction

endpackage

// ===== src/calendar_clock_counter.sv =====
// Calendar clock counter: one tick, set or init word in, one time word out.
// Input reg, then result reg; the calendar update is a combinational carry chain.
// Throughput: one word per cycle while out_stall is low.
// Reset (synchronous, rst_n low): calendar goes to year 0, Jan 1, 00:00:00,
// Monday; both pipeline stages empty.
// Depends on ccc_pkg and ccc_update.
module calendar_clock_counter
  import ccc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_data
);

  logic      in_valid_r, in_valid_nxt;
  in_word_t  in_data_r;
  cal_t      cal_r, cal_nxt;
  logic      out_valid_r, out_valid_nxt;
  out_word_t out_data_r, out_data_nxt;
  cal_t      upd_cal;
  logic      upd_minute;
  logic      advance;
  logic      fire;

  // Result stage can load when empty or being drained
  assign advance  = !out_valid_r || !out_stall;
  assign fire     = in_valid_r && advance;
  assign in_stall = in_valid_r && !advance;

  ccc_update u_update (
    .cur          (cal_r),
    .item         (in_data_r),
    .nxt          (upd_cal),
    .minute_event (upd_minute)
  );

  // Stage control and next values
  always_comb begin
    in_valid_nxt  = in_stall ? in_valid_r : in_valid;
    out_valid_nxt = advance ? in_valid_r : out_valid_r;
    cal_nxt       = fire ? upd_cal : cal_r;
    out_data_nxt  = out_data_r;
    if (fire) begin
      out_data_nxt = '{
        cur_year:     upd_cal.year,
        cur_month:    upd_cal.month,
        cur_day:      upd_cal.day,
        cur_hour:     upd_cal.hour,
        cur_minute:   upd_cal.minute,
        cur_second:   upd_cal.second,
        cur_weekday:  upd_cal.weekday,
        minute_event: upd_minute
      };
    end
  end

  // Control and calendar registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      cal_r       <= CAL_INIT;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
      cal_r       <= cal_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (!in_stall) begin
      in_data_r <= in_data;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  // Calendar fields stay in their legal ranges
  a_cal_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cal_r.month >= 4'd1) && (cal_r.month <= 4'd12) && (cal_r.day >= 5'd1) &&
    (cal_r.hour <= 5'd23) && (cal_r.minute <= 6'd59) && (cal_r.second <= 6'd59) &&
    (cal_r.weekday <= 3'd6))
    else $error("calendar state out of range");

  // A minute rollover always reports second zero
  a_minute_sec: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.minute_event) |-> (out_data_r.cur_second == 6'd0))
    else $error("minute event without second zero");

  // A held input word is not dropped while the result stage is blocked
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && !advance) |=> (in_valid_r && $stable(in_data_r) && $stable(cal_r)))
    else $error("held input word lost or state changed");

  // Result shown matches the calendar state it came from
  a_out_state: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> (out_data_r.cur_year == cal_r.year) && (out_data_r.cur_day == cal_r.day) &&
             (out_data_r.cur_weekday == cal_r.weekday))
    else $error("result word differs from calendar state");
`endif

endmodule

// ===== src/ccc_update.sv =====
// Next-state logic of the calendar: tick carry chain, masked set, init.
// Depends on ccc_pkg.
module ccc_update
  import ccc_pkg::*;
(
  input  cal_t     cur,
  input  in_word_t item,
  output cal_t     nxt,
  output logic     minute_event
);

  logic       sec_wrap;
  logic       min_wrap;
  logic       hour_wrap;
  logic       day_wrap;
  logic       month_wrap;
  logic [5:0] day_limit;
  logic [5:0] day_inc;
  cal_t       tick_val;
  cal_t       set_val;

  // Carry chain for one second
  always_comb begin
    day_limit = {1'b0, month_len(cur.month)};
    if (cur.month == MONTH_FEB && cur.year[1:0] == 2'b00) begin
      day_limit = day_limit + 6'd1;
    end
    day_inc    = {1'b0, cur.day} + 6'd1;
    sec_wrap   = cur.second >= SECOND_LAST;
    min_wrap   = sec_wrap && (cur.minute >= MINUTE_LAST);
    hour_wrap  = min_wrap && (cur.hour >= HOUR_LAST);
    day_wrap   = hour_wrap && (day_inc > day_limit);
    month_wrap = day_wrap && (cur.month >= MONTH_LAST);

    tick_val        = cur;
    tick_val.second = sec_wrap ? 6'd0 : cur.second + 6'd1;
    if (sec_wrap) begin
      tick_val.minute = min_wrap ? 6'd0 : cur.minute + 6'd1;
    end
    if (min_wrap) begin
      tick_val.hour = hour_wrap ? 5'd0 : cur.hour + 5'd1;
    end
    if (hour_wrap) begin
      tick_val.weekday = (cur.weekday >= WDAY_LAST) ? 3'd0 : cur.weekday + 3'd1;
      tick_val.day     = day_wrap ? 5'd1 : day_inc[4:0];
    end
    if (day_wrap) begin
      tick_val.month = month_wrap ? 4'd1 : cur.month + 4'd1;
    end
    if (month_wrap && cur.year != YEAR_MAX) begin
      tick_val.year = cur.year + 16'd1;
    end
  end

  // Masked set; year taken as is, weekday mod 7, rest range-checked
  always_comb begin
    set_val = cur;
    if (item.write_mask[MSK_YEAR]) begin
      set_val.year = item.new_year;
    end
    if (item.write_mask[MSK_MONTH] && (item.new_month inside {[8'd1:8'd12]})) begin
      set_val.month = item.new_month[3:0];
    end
    if (item.write_mask[MSK_DAY] && (item.new_day inside {[8'd1:8'd31]})) begin
      set_val.day = item.new_day[4:0];
    end
    if (item.write_mask[MSK_HOUR] && item.new_hour <= 8'd23) begin
      set_val.hour = item.new_hour[4:0];
    end
    if (item.write_mask[MSK_MINUTE] && item.new_minute <= 8'd59) begin
      set_val.minute = item.new_minute[5:0];
    end
    if (item.write_mask[MSK_SECOND] && item.new_second <= 8'd59) begin
      set_val.second = item.new_second[5:0];
    end
    if (item.write_mask[MSK_WEEKDAY]) begin
      set_val.weekday = mod7(item.new_weekday);
    end
  end

  // Select by item code; the unused code holds the state
  always_comb begin
    nxt          = cur;
    minute_event = 1'b0;
    case (item.action)
      ACT_TICK: begin
        nxt          = tick_val;
        minute_event = sec_wrap;
      end
      ACT_SET:  nxt = set_val;
      ACT_INIT: nxt = CAL_INIT;
      default:  nxt = cur;
    endcase
  end

endmodule
